// File: hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// shared widths, request and status codes, default sizes for the allocator
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int REQ_W  = 2;
	localparam int SIZE_W = 16;
	localparam int OFF_W  = 17;
	localparam int STAT_W = 3;
	localparam int LGB_W  = 4;
	localparam int SH_W   = 5;

	localparam int SEGMENTS_DEF  = 16;
	localparam int LG_BLOCKS_DEF = 5;

	localparam logic [LGB_W-1:0] LG_BASE_RESET = 4'd4;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 3'd1;
	localparam logic [STAT_W-1:0] STATUS_NO_SEG    = 3'd2;
	localparam logic [STAT_W-1:0] STATUS_RANGE     = 3'd3;
	localparam logic [STAT_W-1:0] STATUS_NOT_ALLOC = 3'd4;

endpackage

// File: hdl/psa_ifs.sv
// ----------------------------------------------------------------------------
// psa interfaces
// request, response and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface psa_req_if;
	import psa_pkg::*;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [SIZE_W-1:0] request_size;
	logic [OFF_W-1:0]  block_offset;
	modport source (output valid, req_type, request_size, block_offset, input ready);
	modport sink (input valid, req_type, request_size, block_offset, output ready);
endinterface

interface psa_rsp_if;
	import psa_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [OFF_W-1:0]  result_offset;
	logic              in_use;
	modport source (output valid, status, result_offset, in_use, input ready);
	modport sink (input valid, status, result_offset, in_use, output ready);
endinterface

interface psa_cfg_if;
	import psa_pkg::*;
	logic             valid;
	logic             ready;
	logic [LGB_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: hdl/pow2_slab_allocator.sv
// ----------------------------------------------------------------------------
// pow2_slab_allocator
// power-of-two segregated slab allocator with per-segment free bitmaps
// ----------------------------------------------------------------------------
// Requests are handled one at a time by a small sequencer around a single
// segment record memory (one read and one write port, registered read).
// After reset a clearing pass over every segment record builds the free list;
// no request is taken meanwhile. An allocate finds its bucket by shifting
// (size - 1) >> lg_base_size one bit at a time, takes a segment off the free
// list when that bucket is empty (failing when none is left), scans the
// segment's free bitmap and unlinks the segment when it fills. A free puts
// a full segment back on its bucket list, an emptied one on the free list;
// a check only reads the record. A too-large request, an out-of-range
// offset or an unknown type goes straight to the result. The result goes to
// an output register, so a new request may be taken while the previous
// result waits; the last step of the next request waits until it is taken.
module pow2_slab_allocator #(
	parameter int SEGMENTS  = psa_pkg::SEGMENTS_DEF,
	parameter int LG_BLOCKS = psa_pkg::LG_BLOCKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	psa_cfg_if.sink   cfg,
	psa_req_if.sink   req,
	psa_rsp_if.source rsp
);
	import psa_pkg::*;

	localparam int NB        = 1 << LG_BLOCKS;
	localparam int CW        = LG_BLOCKS + 1;
	localparam int BW        = $clog2(LG_BLOCKS + 1);
	localparam int NL        = LG_BLOCKS + 2;
	localparam int LW        = $clog2(NL);
	localparam int SW        = $clog2(SEGMENTS);
	localparam int LKW       = $clog2(SEGMENTS + 1);
	localparam int SSW       = LG_BLOCKS + 16;
	localparam int ASW       = SSW + SW + 1;
	localparam int FREE_LIST = LG_BLOCKS + 1;

	localparam logic [LKW-1:0] NIL      = LKW'(SEGMENTS);
	localparam logic [LW-1:0]  FREE_IDX = LW'(FREE_LIST);

	typedef struct packed {
		logic [NB-1:0]  fb;
		logic [CW-1:0]  cnt;
		logic [BW-1:0]  bkt;
		logic [LKW-1:0] nxt;
		logic [LKW-1:0] prv;
	} seg_rec_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_BKT, S_ALC_CHK, S_ALC_FREE, S_ALC_PUSH, S_ALC_LD,
		S_SCAN, S_FC_LD, S_FC_EVAL, S_FC_REL, S_FC_TOFREE, S_RM_P, S_RM_PW,
		S_RM_N, S_RM_NW, S_PS, S_PS_W, S_WB, S_DONE
	} state_t;

	function automatic logic [CW-1:0] nb_of(input logic [LW-1:0] b);
		nb_of = CW'(1) << (CW'(LG_BLOCKS) - CW'(b));
	endfunction

	seg_rec_t seg_mem [SEGMENTS];
	seg_rec_t rd_data_q;
	seg_rec_t cur_q;
	seg_rec_t wr_data;
	logic             wr_en;
	logic [SW-1:0]    wr_addr;
	logic [SW-1:0]    rd_addr;

	state_t            state_q;
	state_t            ret_q;
	logic [LGB_W-1:0]  lg_q;
	logic [LKW-1:0]    front_q [NL];
	logic [SW-1:0]     init_q;
	logic [SW-1:0]     seg_q;
	logic [LKW-1:0]    aux_q;
	logic [LW-1:0]     lst_q;
	logic [LW-1:0]     b_q;
	logic [SH_W-1:0]   bk_q;
	logic [SIZE_W-1:0] s_q;
	logic [OFF_W-1:0]  off_q;
	logic [LG_BLOCKS-1:0] scan_q;
	logic [LG_BLOCKS-1:0] blk_q;
	logic [STAT_W-1:0] st_status_q;
	logic [OFF_W-1:0]  st_res_q;
	logic              st_inuse_q;
	logic              ov_q;
	logic [STAT_W-1:0] status_q;
	logic [OFF_W-1:0]  res_q;
	logic              inuse_q;
	logic              req_type_check_q;

	logic [SH_W-1:0]  lgseg;
	logic [SSW-1:0]   segsize;
	logic [ASW-1:0]   area;
	logic [SW-1:0]    req_seg;
	logic [CW-1:0]    nb_alloc;
	logic [CW-1:0]    nb_cur;
	logic [CW-1:0]    nb_rd;
	logic [OFF_W-1:0] in_seg;
	logic [OFF_W-1:0] blk_sh;
	logic [OFF_W-1:0] res_w;
	logic             used;
	seg_rec_t         init_rec;

	assign lgseg    = SH_W'(LG_BLOCKS) + SH_W'(lg_q);
	assign segsize  = SSW'(1) << lgseg;
	assign area     = ASW'(SEGMENTS) << lgseg;
	assign req_seg  = SW'(req.block_offset >> lgseg);
	assign nb_alloc = nb_of(b_q);
	assign nb_cur   = nb_of(LW'(cur_q.bkt));
	assign nb_rd    = nb_of(LW'(rd_data_q.bkt));
	assign in_seg   = off_q & OFF_W'(segsize - SSW'(1));
	assign blk_sh   = in_seg >> (SH_W'(lg_q) + SH_W'(rd_data_q.bkt));
	assign res_w    = OFF_W'({{OFF_W{1'b0}}, seg_q} << lgseg)
		+ OFF_W'({{OFF_W{1'b0}}, scan_q} << (SH_W'(lg_q) + SH_W'(b_q)));
	assign used     = (cur_q.cnt != '0) && !cur_q.fb[blk_q];

	always_comb begin
		init_rec.fb  = '1;
		init_rec.cnt = '0;
		init_rec.bkt = '0;
		init_rec.nxt = (init_q == '0) ? NIL : LKW'(init_q) - LKW'(1);
		init_rec.prv = (init_q == SW'(SEGMENTS - 1)) ? NIL : LKW'(init_q) + LKW'(1);
	end

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = seg_q;
		wr_data = cur_q;
		case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = init_q;
				wr_data = init_rec;
			end
			S_IDLE: rd_addr = req_seg;
			S_ALC_CHK: begin
				if (front_q[b_q] == NIL) begin
					rd_addr = front_q[FREE_IDX][SW-1:0];
				end else begin
					rd_addr = front_q[b_q][SW-1:0];
				end
			end
			S_RM_P: rd_addr = cur_q.prv[SW-1:0];
			S_RM_PW: begin
				wr_en       = 1'b1;
				wr_addr     = cur_q.prv[SW-1:0];
				wr_data     = rd_data_q;
				wr_data.nxt = cur_q.nxt;
			end
			S_RM_N: rd_addr = cur_q.nxt[SW-1:0];
			S_RM_NW: begin
				wr_en       = 1'b1;
				wr_addr     = cur_q.nxt[SW-1:0];
				wr_data     = rd_data_q;
				wr_data.prv = cur_q.prv;
			end
			S_PS: rd_addr = front_q[lst_q][SW-1:0];
			S_PS_W: begin
				wr_en       = 1'b1;
				wr_addr     = aux_q[SW-1:0];
				wr_data     = rd_data_q;
				wr_data.prv = LKW'(seg_q);
			end
			S_WB: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= seg_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LG_BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			lg_q <= cfg.data;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.status = status_q;
	assign rsp.result_offset = res_q;
	assign rsp.in_use = inuse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_WB;
			init_q  <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < NL; i++) begin
				front_q[i] <= (i == FREE_LIST) ? LKW'(SEGMENTS - 1) : NIL;
			end
		end else begin
			if (ov_q && rsp.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + SW'(1);
					if (init_q == SW'(SEGMENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						st_status_q <= STATUS_OK;
						st_res_q    <= '0;
						st_inuse_q  <= 1'b0;
						off_q       <= req.block_offset;
						seg_q       <= req_seg;
						bk_q        <= '0;
						s_q         <= (req.request_size == '0) ? '0
							: (req.request_size - SIZE_W'(1)) >> lg_q;
						case (req.req_type)
							REQ_ALLOC: begin
								if (SSW'(req.request_size) > segsize) begin
									st_status_q <= STATUS_TOO_LARGE;
									state_q     <= S_DONE;
								end else begin
									state_q <= S_BKT;
								end
							end
							REQ_FREE, REQ_CHECK: begin
								if (ASW'(req.block_offset) >= area) begin
									st_status_q <= STATUS_RANGE;
									state_q     <= S_DONE;
								end else begin
									state_q <= S_FC_LD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_BKT: begin
					if (s_q != '0) begin
						s_q  <= s_q >> 1;
						bk_q <= bk_q + SH_W'(1);
					end else begin
						b_q     <= (bk_q > SH_W'(LG_BLOCKS)) ? LW'(LG_BLOCKS) : LW'(bk_q);
						state_q <= S_ALC_CHK;
					end
				end
				S_ALC_CHK: begin
					if (front_q[b_q] == NIL) begin
						if (front_q[FREE_IDX] == NIL) begin
							st_status_q <= STATUS_NO_SEG;
							state_q     <= S_DONE;
						end else begin
							seg_q   <= front_q[FREE_IDX][SW-1:0];
							state_q <= S_ALC_FREE;
						end
					end else begin
						seg_q   <= front_q[b_q][SW-1:0];
						state_q <= S_ALC_LD;
					end
				end
				S_ALC_FREE: begin
					cur_q   <= rd_data_q;
					lst_q   <= FREE_IDX;
					ret_q   <= S_ALC_PUSH;
					state_q <= S_RM_P;
				end
				S_ALC_PUSH: begin
					cur_q.bkt <= BW'(b_q);
					lst_q     <= b_q;
					scan_q    <= '0;
					ret_q     <= S_SCAN;
					state_q   <= S_PS;
				end
				S_ALC_LD: begin
					cur_q   <= rd_data_q;
					scan_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cur_q.fb[scan_q]) begin
						cur_q.fb[scan_q] <= 1'b0;
						cur_q.cnt        <= cur_q.cnt + CW'(1);
						st_res_q         <= res_w;
						if (cur_q.cnt + CW'(1) >= nb_alloc) begin
							lst_q   <= b_q;
							ret_q   <= S_WB;
							state_q <= S_RM_P;
						end else begin
							state_q <= S_WB;
						end
					end else if (CW'(scan_q) == nb_alloc - CW'(1)) begin
						st_status_q <= STATUS_NO_SEG;
						state_q     <= S_WB;
					end else begin
						scan_q <= scan_q + LG_BLOCKS'(1);
					end
				end
				S_FC_LD: begin
					cur_q   <= rd_data_q;
					blk_q   <= (blk_sh >= OFF_W'(nb_rd)) ? LG_BLOCKS'(nb_rd - CW'(1))
						: blk_sh[LG_BLOCKS-1:0];
					state_q <= S_FC_EVAL;
				end
				S_FC_EVAL: begin
					b_q <= LW'(cur_q.bkt);
					if (req_type_check_q) begin
						st_inuse_q <= used;
						state_q    <= S_DONE;
					end else if (!used) begin
						st_status_q <= STATUS_NOT_ALLOC;
						state_q     <= S_DONE;
					end else if (cur_q.cnt >= nb_cur) begin
						lst_q   <= LW'(cur_q.bkt);
						ret_q   <= S_FC_REL;
						state_q <= S_PS;
					end else begin
						state_q <= S_FC_REL;
					end
				end
				S_FC_REL: begin
					cur_q.fb[blk_q] <= 1'b1;
					cur_q.cnt       <= cur_q.cnt - CW'(1);
					if (cur_q.cnt == CW'(1)) begin
						lst_q   <= b_q;
						ret_q   <= S_FC_TOFREE;
						state_q <= S_RM_P;
					end else begin
						state_q <= S_WB;
					end
				end
				S_FC_TOFREE: begin
					lst_q   <= FREE_IDX;
					ret_q   <= S_WB;
					state_q <= S_PS;
				end
				S_RM_P: begin
					if (cur_q.prv != NIL) begin
						state_q <= S_RM_PW;
					end else begin
						front_q[lst_q] <= cur_q.nxt;
						state_q        <= S_RM_N;
					end
				end
				S_RM_PW: state_q <= S_RM_N;
				S_RM_N: begin
					if (cur_q.nxt != NIL) begin
						state_q <= S_RM_NW;
					end else begin
						cur_q.prv <= NIL;
						state_q   <= ret_q;
					end
				end
				S_RM_NW: begin
					cur_q.nxt <= NIL;
					cur_q.prv <= NIL;
					state_q   <= ret_q;
				end
				S_PS: begin
					cur_q.nxt      <= front_q[lst_q];
					cur_q.prv      <= NIL;
					front_q[lst_q] <= LKW'(seg_q);
					aux_q          <= front_q[lst_q];
					state_q        <= (front_q[lst_q] != NIL) ? S_PS_W : ret_q;
				end
				S_PS_W: state_q <= ret_q;
				S_WB: state_q <= S_DONE;
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q     <= 1'b1;
						status_q <= st_status_q;
						res_q    <= st_res_q;
						inuse_q  <= st_inuse_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_type_check_q <= 1'b0;
		end else if (state_q == S_IDLE && req.valid) begin
			req_type_check_q <= (req.req_type == REQ_CHECK);
		end
	end

endmodule

// File: test/pow2_slab_allocator_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_slab_allocator_tb_pkg
// allocator state mirror that predicts every response, and a response scoreboard
// ----------------------------------------------------------------------------
package pow2_slab_allocator_tb_pkg;
	import psa_pkg::*;

	localparam int NSEG  = SEGMENTS_DEF;
	localparam int LGBLK = LG_BLOCKS_DEF;
	localparam int FREE_Q = LGBLK + 1;
	localparam int NONE  = NSEG;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFF_W-1:0]  result_offset;
		logic              in_use;
	} alloc_rsp_t;

	class slab_scoreboard;
		logic [LGB_W-1:0] lg_base;
		logic [31:0] bitmap [NSEG];
		int          used [NSEG];
		int          bucket_of [NSEG];
		int          nxt [NSEG];
		int          prv [NSEG];
		int          front [LGBLK+2];
		alloc_rsp_t  pending [$];
		int          errors;

		function new();
			lg_base = LG_BASE_RESET;
			errors = 0;
			for (int i = 0; i < LGBLK + 2; i++) front[i] = NONE;
			for (int i = 0; i < NSEG; i++) begin
				bitmap[i] = '1;
				used[i] = 0;
				bucket_of[i] = 0;
				nxt[i] = NONE;
				prv[i] = NONE;
			end
			for (int i = 0; i < NSEG; i++) push_front(i, FREE_Q);
		endfunction

		function void push_front(int seg, int l);
			int f;
			f = front[l];
			nxt[seg] = f;
			prv[seg] = NONE;
			if (f < NSEG) prv[f] = seg;
			front[l] = seg;
		endfunction

		function void unlink(int seg, int l);
			int p, n;
			p = prv[seg];
			n = nxt[seg];
			if (p < NSEG) nxt[p] = n;
			else front[l] = n;
			if (n < NSEG) prv[n] = p;
			nxt[seg] = NONE;
			prv[seg] = NONE;
		endfunction

		function void set_base(logic [LGB_W-1:0] v);
			lg_base = v;
		endfunction

		function bit idle();
			return pending.size() == 0;
		endfunction

		function void note_request(logic [REQ_W-1:0] kind, logic [SIZE_W-1:0] size,
				logic [OFF_W-1:0] off);
			alloc_rsp_t r;
			int lg, lgseg, b, seg, nb, blk, idx;
			longint segsize, s, res;
			bit hit, busy;
			r = '0;
			lg = lg_base;
			lgseg = LGBLK + lg;
			segsize = longint'(1) << lgseg;
			if (kind == REQ_ALLOC) begin
				if (size > segsize) r.status = STATUS_TOO_LARGE;
				else begin
					b = 0;
					s = (size != 0) ? ((longint'(size) - 1) >> lg) : 0;
					while (s != 0) begin
						s = s >> 1;
						b++;
					end
					if (b > LGBLK) b = LGBLK;
					if (front[b] >= NSEG) begin
						seg = front[FREE_Q];
						if (seg >= NSEG) r.status = STATUS_NO_SEG;
						else begin
							unlink(seg, FREE_Q);
							push_front(seg, b);
							bucket_of[seg] = b;
						end
					end
					if (r.status == STATUS_OK) begin
						seg = front[b];
						nb = 1 << (LGBLK - b);
						hit = 0;
						idx = 0;
						for (int i = 0; i < nb; i++)
							if (!hit && bitmap[seg][i]) begin
								hit = 1;
								idx = i;
							end
						if (!hit) r.status = STATUS_NO_SEG;
						else begin
							bitmap[seg][idx] = 1'b0;
							used[seg]++;
							if (used[seg] >= nb) unlink(seg, b);
							res = (longint'(seg) << lgseg) + (longint'(idx) << (lg + b));
							r.result_offset = res[OFF_W-1:0];
						end
					end
				end
			end else if (kind == REQ_FREE || kind == REQ_CHECK) begin
				if (longint'(off) >= NSEG * segsize) r.status = STATUS_RANGE;
				else begin
					seg = int'(longint'(off) >> lgseg);
					b = bucket_of[seg];
					nb = 1 << (LGBLK - b);
					blk = int'((longint'(off) & (segsize - 1)) >> (lg + b));
					if (blk >= nb) blk = nb - 1;
					busy = used[seg] != 0 && !bitmap[seg][blk];
					if (kind == REQ_CHECK) r.in_use = busy;
					else if (!busy) r.status = STATUS_NOT_ALLOC;
					else begin
						if (used[seg] >= nb) push_front(seg, b);
						bitmap[seg][blk] = 1'b1;
						used[seg]--;
						if (used[seg] == 0) begin
							unlink(seg, b);
							push_front(seg, FREE_Q);
						end
					end
				end
			end
			pending.push_back(r);
		endfunction

		task check_response(alloc_rsp_t got);
			alloc_rsp_t want;
			if (pending.size() == 0) begin
				report("unexpected response", got, '0);
				return;
			end
			want = pending.pop_front();
			if (got.status != want.status) report("status", got, want);
			if (got.result_offset != want.result_offset) report("result_offset", got, want);
			if (got.in_use != want.in_use) report("in_use", got, want);
		endtask

		task report(string what, alloc_rsp_t got, alloc_rsp_t want);
			errors++;
			$display("mismatch %s: got %0d/%0h/%0d want %0d/%0h/%0d", what,
				got.status, got.result_offset, got.in_use,
				want.status, want.result_offset, want.in_use);
		endtask
	endclass
endpackage

// File: test/pow2_slab_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_slab_allocator_tb
// random and directed allocate/free/check traffic with a mirrored allocator
// ----------------------------------------------------------------------------
module pow2_slab_allocator_tb;
	import psa_pkg::*;
	import pow2_slab_allocator_tb_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk = 0;
	logic arst_n = 0;

	psa_cfg_if cfg ();
	psa_req_if req ();
	psa_rsp_if rsp ();

	pow2_slab_allocator dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp));

	slab_scoreboard sb = new();
	logic [OFF_W-1:0] live [$];
	bit calm = 0;
	int hold_off = 0;

	always #6 clk = ~clk;

	initial begin
		cfg.valid = 0;
		cfg.data = '0;
		req.valid = 0;
		req.req_type = REQ_ALLOC;
		req.request_size = '0;
		req.block_offset = '0;
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(alloc_rsp_t'{rsp.status, rsp.result_offset, rsp.in_use});
		if (arst_n && req.valid && req.ready) begin
			sb.note_request(req.req_type, req.request_size, req.block_offset);
			if (req.req_type == REQ_ALLOC && sb.pending[$].status == STATUS_OK)
				live.push_back(sb.pending[$].result_offset);
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				rsp.ready <= 0;
				hold_off--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 12);
				rsp.ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else
				rsp.ready <= 1;
		end
	end

	task automatic send(logic [REQ_W-1:0] kind, logic [SIZE_W-1:0] size,
			logic [OFF_W-1:0] off);
		if (!calm && $urandom_range(0, 9) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req.valid <= 1;
		req.req_type <= kind;
		req.request_size <= size;
		req.block_offset <= off;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (!sb.idle()) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_base(logic [LGB_W-1:0] v);
		cfg.valid <= 1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_base(v);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic free_some();
		int k;
		while (live.size() > 0 && $urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, live.size() - 1);
			send(REQ_FREE, '0, live[k] | OFF_W'($urandom_range(0, 3)));
			live.delete(k);
		end
	endtask

	function automatic logic [REQ_W-1:0] REQ_line(int r);
		return (r & 1) ? REQ_FREE : REQ_CHECK;
	endfunction

	task automatic random_phase(int count);
		int r;
		logic [SIZE_W-1:0] sz;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				sz = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom)
					: SIZE_W'($urandom_range(0, 1 << ($urandom_range(0, 9))));
				send(REQ_ALLOC, sz, OFF_W'($urandom));
			end else if (r < 70 && live.size() > 0) begin
				r = $urandom_range(0, live.size() - 1);
				send(REQ_FREE, SIZE_W'($urandom), live[r]);
				live.delete(r);
			end else if (r < 85 && live.size() > 0)
				send(REQ_CHECK, SIZE_W'($urandom), live[$urandom_range(0, live.size() - 1)]);
			else if (r < 97)
				send(REQ_line(r), SIZE_W'($urandom), OFF_W'($urandom_range(0, 20000)));
			else
				send(REQ_UNUSED, SIZE_W'($urandom), OFF_W'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed
		send(REQ_ALLOC, 16'd0, '0);
		send(REQ_ALLOC, 16'd1, '0);
		send(REQ_ALLOC, 16'd17, '0);
		send(REQ_ALLOC, 16'd512, '0);
		send(REQ_ALLOC, 16'd513, '0);
		send(REQ_ALLOC, 16'hFFFF, '0);
		send(REQ_CHECK, '0, 17'd0);
		send(REQ_CHECK, '0, 17'd5);
		send(REQ_FREE, '0, 17'd3);
		send(REQ_FREE, '0, 17'd3);
		send(REQ_CHECK, '0, 17'd8191);
		send(REQ_CHECK, '0, 17'd8192);
		send(REQ_FREE, '0, 17'h1FFFF);
		send(REQ_UNUSED, 16'hFFFF, 17'h1FFFF);
		for (int i = 0; i < 10; i++) send(REQ_ALLOC, 16'd512, '0);
		send(REQ_ALLOC, 16'd16, '0);
		drain();
		set_base(4'd0);
		for (int i = 0; i < 520; i++) send(REQ_ALLOC, 16'd1, '0);
		free_some();
		drain();
		// long receiver hold-off while requests keep coming
		hold_off = 300;
		random_phase(40);
		drain();
		set_base(4'd8);
		random_phase(150);
		free_some();
		drain();
		set_base(4'd12);
		random_phase(60);
		drain();
		set_base(4'd2);
		random_phase(150);
		drain();
		set_base(4'd15);
		random_phase(40);
		drain();
		set_base(4'd4);
		random_phase(100);
		calm = 1;
		random_phase(80);
		drain();
		if (sb.errors == 0 && sb.idle())
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
